>>> hw/rtl/gem_pkg.sv
`default_nettype none

package gem_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int GRAD_W     = 24;
    localparam int MAG_W      = GRAD_W - 1;
    localparam int SS_W       = 2 * MAG_W;
    localparam int ROOT_W     = SS_W / 2 + 8;
    localparam int RAD_W      = SS_W + 16;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ITER_W     = 5;
    localparam int GAIN_W     = 32;
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int ROW_W      = 17;
    localparam int ITEMS_W    = 27;
    localparam int LINES_HELD = 4;
    localparam int LSEL_W     = 2;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [ROW_W-1:0]   ROW_CAP   = '1;
    localparam logic [ITEMS_W-1:0] ITEMS_CAP = '1;

    // Register port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_KIND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS    = 3'd5;

    localparam logic [10:0]           RST_FRAME_WIDTH    = 11'd1024;
    localparam logic [15:0]           RST_FRAME_HEIGHT   = 16'd480;
    localparam logic [1:0]            RST_KERNEL_KIND    = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RST_THRESHOLD_SQ   = 50'd640000;
    localparam logic [GAIN_W-1:0]     RST_MAGNITUDE_GAIN = 32'd270600;
    localparam logic [4:0]            RST_SAMPLE_BITS    = 5'd8;

    // Kernel codes
    localparam logic [1:0] KIND_CROSS2 = 2'd0;
    localparam logic [1:0] KIND_CROSS5 = 2'd1;
    localparam logic [1:0] KIND_SOBEL  = 2'd2;

    localparam logic signed [GRAD_W-1:0] W_OUTER = 24'sd12;
    localparam logic signed [GRAD_W-1:0] W_INNER = 24'sd74;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
        logic                pad;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mask;
        logic                mask_valid;
        logic                frame_end;
    } result_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     active;
        logic                     valid;
        logic                     last;
    } grad_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] threshold_sq;
        logic [GAIN_W-1:0]     gain;
        logic [SAMPLE_W-1:0]   mask_max;
    } back_cfg_t;

    typedef struct packed {
        logic       clearing;
        logic [1:0] in_flight;
    } front_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_MUL,
        ST_ROUND,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/gem_front.sv
`default_nettype none

module gem_front
    import gem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int TW = WW + 16,
    localparam int LW = WW + 2
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire in_item_t        item,
    input  wire logic [WW-1:0]   w_eff,
    input  wire logic [15:0]     h_eff,
    input  wire logic [1:0]      kind,
    input  wire logic [LW-1:0]   lag,
    input  wire logic [TW-1:0]   total,
    output front_status_t        status,
    output logic                 push,
    output grad_item_t           push_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = ((TW > ITEMS_W) ? TW : ITEMS_W) + 1;
    localparam int RW = ROW_W + 1;
    localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);

    // Position counters and clearing sweep
    logic [CW-1:0]       col_reg, col_next, c_in;
    logic [ROW_W-1:0]    row_reg, row_next, r_in;
    logic [ITEMS_W-1:0]  items_reg, items_next, p_in;
    logic [SAMPLE_W-1:0] sample_in;
    logic                line_end;
    logic                clr_busy_reg;
    logic [CW-1:0]       clr_addr_reg;

    // Line read data, stage one and stage two
    logic [SAMPLE_W-1:0] rd_reg [LINES_HELD];
    logic                s1_v_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [ITEMS_W-1:0]  s1_p_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SAMPLE_W-1:0] colv [5];
    logic [SAMPLE_W-1:0] taps_reg [5][5];
    logic                valid1, last1, inside1;
    logic                s2_v_reg, s2_valid_reg, s2_last_reg, s2_active_reg;

    logic [DW-1:0]       p_ext, lag_ext, total_ext, offset;
    logic                c_big;
    logic [WW:0]         ccol, skip_c, w_ext;
    logic [RW-1:0]       r_ext, h_ext, roff, skip_r;

    logic signed [GRAD_W-1:0] t_top, t_bottom, t_left, t_right;
    logic signed [GRAD_W-1:0] t_top2, t_bottom2, t_left2, t_right2;
    logic signed [GRAD_W-1:0] t_tl, t_tr, t_bl, t_br;
    logic signed [GRAD_W-1:0] gx, gy;

    // Position of the incoming sample
    always_comb
    begin
        c_in       = item.frame_start ? '0 : col_reg;
        r_in       = item.frame_start ? '0 : row_reg;
        p_in       = item.frame_start ? '0 : items_reg;
        sample_in  = item.pad ? '0 : item.sample;
        line_end   = (32'(c_in) + 32'd1) >= 32'(w_eff);
        col_next   = line_end ? '0 : c_in + CW'(1);
        row_next   = (line_end && (r_in != ROW_CAP)) ? r_in + ROW_W'(1) : r_in;
        items_next = (p_in != ITEMS_CAP) ? p_in + ITEMS_W'(1) : p_in;
    end

    // Advance counters; sweep the line store once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            items_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                items_reg <= items_next;
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == LAST_COL)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Line store: one bank per held line, read at the current column
    for (genvar b = 0; b < LINES_HELD; b++)
    begin : g_bank
        logic [SAMPLE_W-1:0] bank_mem [MAX_WIDTH];
        logic                bank_we;
        logic [CW-1:0]       bank_waddr;
        logic [SAMPLE_W-1:0] bank_wdata;

        always_comb
        begin
            bank_we    = clr_busy_reg || (accept && (r_in[LSEL_W-1:0] == LSEL_W'(b)));
            bank_waddr = clr_busy_reg ? clr_addr_reg : c_in;
            bank_wdata = clr_busy_reg ? '0 : sample_in;
        end

        always_ff @(posedge clk)
        begin
            if (bank_we)
            begin
                bank_mem[bank_waddr] <= bank_wdata;
            end
            rd_reg[b] <= bank_mem[c_in];
        end
    end

    // Stage one: hold the accepted request while the lines are read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= c_in;
            s1_row_reg    <= r_in;
            s1_p_reg      <= p_in;
            s1_sample_reg <= sample_in;
        end
    end

    // Column entering the window, oldest line on top
    always_comb
    begin
        for (int k = 0; k < LINES_HELD; k++)
        begin
            colv[k] = rd_reg[LSEL_W'(s1_row_reg[LSEL_W-1:0] + LSEL_W'(k))];
        end
        colv[4] = s1_sample_reg;
    end

    // Classify the output position: frame pixel, last pixel, inside border
    always_comb
    begin
        p_ext     = DW'(s1_p_reg);
        lag_ext   = DW'(lag);
        total_ext = DW'(total);
        offset    = p_ext - lag_ext;
        valid1    = (p_ext >= lag_ext) && (offset < total_ext);
        last1     = valid1 && (offset == (total_ext - DW'(1)));

        c_big  = s1_col_reg >= CW'(2);
        w_ext  = (WW+1)'(w_eff);
        ccol   = c_big ? (WW+1)'(s1_col_reg) - (WW+1)'(2)
                       : (WW+1)'(s1_col_reg) + w_ext - (WW+1)'(2);
        skip_c = (kind == KIND_CROSS5) ? (WW+1)'(2) : (WW+1)'(1);
        skip_r = (kind == KIND_CROSS5) ? RW'(2) : RW'(1);
        roff   = c_big ? RW'(2) : RW'(3);
        r_ext  = RW'(s1_row_reg);
        h_ext  = RW'(h_eff);

        inside1 = (r_ext >= roff + skip_r) && ((r_ext + skip_r) < (h_ext + roff))
               && (ccol >= skip_c) && ((ccol + skip_c) < w_ext);
    end

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    taps_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_v_reg)
        begin
            for (int i = 0; i < 5; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    taps_reg[i][j] <= taps_reg[i][j+1];
                end
                taps_reg[i][4] <= colv[i];
            end
        end
    end

    // Stage two flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            s2_valid_reg  <= valid1;
            s2_last_reg   <= last1;
            s2_active_reg <= valid1 && inside1;
        end
    end

    // Gradient of the window centre
    always_comb
    begin
        t_top     = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[1][2]});
        t_bottom  = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[3][2]});
        t_left    = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[2][1]});
        t_right   = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[2][3]});
        t_top2    = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[0][2]});
        t_bottom2 = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[4][2]});
        t_left2   = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[2][0]});
        t_right2  = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[2][4]});
        t_tl      = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[1][1]});
        t_tr      = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[1][3]});
        t_bl      = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[3][1]});
        t_br      = $signed({{(GRAD_W-SAMPLE_W){1'b0}}, taps_reg[3][3]});

        unique case (kind)
            KIND_CROSS2:
            begin
                gx = t_right - t_left;
                gy = t_top - t_bottom;
            end
            KIND_CROSS5:
            begin
                gx = W_OUTER * (t_left2 - t_right2) + W_INNER * (t_right - t_left);
                gy = W_OUTER * (t_bottom2 - t_top2) + W_INNER * (t_top - t_bottom);
            end
            default:
            begin
                gx = t_tr + (t_right <<< 1) + t_br - t_tl - (t_left <<< 1) - t_bl;
                gy = t_bl + (t_bottom <<< 1) + t_br - t_tl - (t_top <<< 1) - t_tr;
            end
        endcase
    end

    // Hand the classified request to the queue
    always_comb
    begin
        push             = s2_v_reg;
        push_item.gx     = gx;
        push_item.gy     = gy;
        push_item.active = s2_active_reg;
        push_item.valid  = s2_valid_reg;
        push_item.last   = s2_last_reg;
        status.clearing  = clr_busy_reg;
        status.in_flight = 2'(s1_v_reg) + 2'(s2_v_reg);
    end

endmodule

`default_nettype wire

>>> hw/rtl/gem_queue.sv
`default_nettype none

module gem_queue
    import gem_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire grad_item_t  push_item,
    input  wire logic        pop,
    output grad_item_t       head,
    output logic             nempty,
    output logic [QCNT_W-1:0] count
);

    grad_item_t          mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign head   = mem_reg[rd_ptr_reg];
    assign nempty = count_reg != '0;
    assign count  = count_reg;

    // Front credit must keep the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < QCNT_W'(Q_DEPTH)))
        else $error("queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue underflow");

endmodule

`default_nettype wire

>>> hw/rtl/gem_back.sv
`default_nettype none

module gem_back
    import gem_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire back_cfg_t   cfg,
    input  wire logic        q_nempty,
    input  wire grad_item_t  q_head,
    output logic             q_pop,
    input  wire logic        pop,
    output logic             empty,
    output result_t          result
);

    back_state_t          state_reg, state_next;
    grad_item_t           work_reg;
    logic [SS_W-1:0]      sqx_reg, sqy_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SAMPLE_W-1:0]  mask_reg;
    logic                 out_v_reg;
    result_t              out_reg;
    logic                 out_load;

    logic [GRAD_W-1:0]    gx_abs, gy_abs;
    logic [SS_W:0]        ss_wide;
    logic [SS_W-1:0]      ss_sum;
    logic                 over_thr;
    logic [REM_W-1:0]     rem_sh, trial;
    logic                 take;
    logic [PROD_W:0]      prod_rnd;
    logic [GAIN_W-1:0]    scaled;

    // Next state and handshakes
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_nempty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:
            begin
                if (!work_reg.active || (cfg.threshold_sq != '0))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_v_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Magnitudes, sum of squares, root step and rounding
    always_comb
    begin
        gx_abs   = work_reg.gx[GRAD_W-1] ? -work_reg.gx : work_reg.gx;
        gy_abs   = work_reg.gy[GRAD_W-1] ? -work_reg.gy : work_reg.gy;
        ss_wide  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        ss_sum   = ss_wide[SS_W-1:0];
        over_thr = CFG_DATA_W'(ss_sum) > cfg.threshold_sq;
        rem_sh   = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial    = {root_reg, 2'b01};
        take     = rem_sh >= trial;
        prod_rnd = {1'b0, prod_reg} + (PROD_W+1)'(64'h8000_0000);
        scaled   = prod_rnd[PROD_W:PROD_W-GAIN_W+1];
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                work_reg <= q_head;
            end
            ST_SQUARE:
            begin
                sqx_reg <= gx_abs[MAG_W-1:0] * gx_abs[MAG_W-1:0];
                sqy_reg <= gy_abs[MAG_W-1:0] * gy_abs[MAG_W-1:0];
            end
            ST_SUM:
            begin
                mask_reg <= (work_reg.active && (cfg.threshold_sq != '0) && over_thr)
                            ? cfg.mask_max : '0;
                rad_reg  <= {ss_sum, 16'b0};
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= ITER_W'(ROOT_W - 1);
            end
            ST_ROOT:
            begin
                rem_reg  <= take ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], take};
                rad_reg  <= rad_reg << 2;
                iter_reg <= iter_reg - ITER_W'(1);
            end
            ST_MUL:
            begin
                prod_reg <= root_reg * cfg.gain;
            end
            ST_ROUND:
            begin
                mask_reg <= (scaled > GAIN_W'(cfg.mask_max)) ? cfg.mask_max
                                                              : scaled[SAMPLE_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Output register: hold until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_v_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.mask       <= mask_reg;
            out_reg.mask_valid <= work_reg.valid;
            out_reg.frame_end  <= work_reg.last;
        end
    end

    assign empty  = !out_v_reg;
    assign result = out_reg;

    // A finished mask never exceeds the sample range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (mask_reg <= cfg.mask_max))
        else $error("mask above the sample range");

endmodule

`default_nettype wire

>>> hw/rtl/gradient_edge_mask_core.sv
// Edge mask core: one sample in per request, one mask result out per request.
// Input queue side: drive item with push; the request is taken when full is low.
// Result queue side: result is valid while empty is low; pop takes it.
// Register port: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while no request is in progress.
// The mask for a pixel comes out 2*width+2 requests after its sample, so a
// frame is flushed with pad requests; items before and after the frame carry
// mask_valid low.
// When nothing waits, a taken request passes stage one, stage two and the
// queue; the back end then squares and sums, and goes to output in threshold
// mode and for border or non-frame positions, or first runs the square root
// (31 bits, one per cycle), multiply and rounding in magnitude mode, on one
// request at a time. The front end and a four-entry queue take a sample
// every cycle until the requests in flight and queued fill the queue. After
// reset full stays high while the line store is swept to zero. A stalled
// result side fills the queue, then raises full.
`default_nettype none

module gradient_edge_mask_core
    import gem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_item_t              item,
    output logic                       empty,
    input  wire logic                  pop,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int TW = WW + 16;
    localparam int LW = WW + 2;

    logic [10:0]           frame_width_reg;
    logic [15:0]           frame_height_reg;
    logic [1:0]            kernel_kind_reg;
    logic [CFG_DATA_W-1:0] threshold_sq_reg;
    logic [GAIN_W-1:0]     magnitude_gain_reg;
    logic [4:0]            sample_bits_reg;

    logic [WW-1:0]         w_eff;
    logic [15:0]           h_eff;
    logic [1:0]            kind_eff;
    logic [4:0]            bits_eff;
    logic [16:0]           pmax_wide;
    logic [LW-1:0]         lag;
    logic [TW-1:0]         total_reg, total_next;
    back_cfg_t             back_cfg;

    logic                  accept;
    front_status_t         status;
    logic                  f_push;
    grad_item_t            f_item;
    logic                  q_pop, q_nempty;
    grad_item_t            q_head;
    logic [QCNT_W-1:0]     q_count;

    // Register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            kernel_kind_reg    <= RST_KERNEL_KIND;
            threshold_sq_reg   <= RST_THRESHOLD_SQ;
            magnitude_gain_reg <= RST_MAGNITUDE_GAIN;
            sample_bits_reg    <= RST_SAMPLE_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[10:0];
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[15:0];
                CFG_KERNEL_KIND:    kernel_kind_reg    <= cfg_data[1:0];
                CFG_THRESHOLD_SQ:   threshold_sq_reg   <= cfg_data;
                CFG_MAGNITUDE_GAIN: magnitude_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_SAMPLE_BITS:    sample_bits_reg    <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp register values into their working ranges
    always_comb
    begin
        if (frame_width_reg < 11'd5)
        begin
            w_eff = WW'(5);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end

        h_eff    = (frame_height_reg < 16'd5) ? 16'd5 : frame_height_reg;
        kind_eff = (kernel_kind_reg > KIND_SOBEL) ? KIND_SOBEL : kernel_kind_reg;

        if (sample_bits_reg < 5'd8)
        begin
            bits_eff = 5'd8;
        end
        else if (sample_bits_reg > 5'd16)
        begin
            bits_eff = 5'd16;
        end
        else
        begin
            bits_eff = sample_bits_reg;
        end
        pmax_wide = (17'd1 << bits_eff) - 17'd1;

        lag        = {1'b0, w_eff, 1'b0} + LW'(2);
        total_next = TW'(w_eff) * TW'(h_eff);

        back_cfg.threshold_sq = threshold_sq_reg;
        back_cfg.gain         = magnitude_gain_reg;
        back_cfg.mask_max     = pmax_wide[SAMPLE_W-1:0];
    end

    // Frame size product, registered from the clamped width and height
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    // Accept only when every request in flight has a queue slot
    assign full   = status.clearing
                 || ((QCNT_W'(status.in_flight) + q_count) >= QCNT_W'(Q_DEPTH));
    assign accept = push && !full;

    gem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .kind      (kind_eff),
        .lag       (lag),
        .total     (total_reg),
        .status    (status),
        .push      (f_push),
        .push_item (f_item)
    );

    gem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_item (f_item),
        .pop       (q_pop),
        .head      (q_head),
        .nempty    (q_nempty),
        .count     (q_count)
    );

    gem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (back_cfg),
        .q_nempty (q_nempty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

`default_nettype wire
